// File: hdl/dprm_pkg.sv
package dprm_pkg;

    localparam int CHANNELS_DEF    = 20;
    localparam int COUNT_BITS_DEF  = 32;

    // Sample width is tied to the fixed s_tdata layout.
    localparam int SAMPLE_BITS = 12;

    localparam int CH_BITS   = 5;
    localparam int BASE_BITS = 12;
    localparam int RATE_BITS = 32;
    localparam int CFG_BITS  = 3;

    localparam logic [CFG_BITS-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_BITS-1:0] REG_WF_LIMIT  = 3'd1;
    localparam logic [CFG_BITS-1:0] REG_SHORT_WIN = 3'd2;
    localparam logic [CFG_BITS-1:0] REG_LONG_WIN  = 3'd3;
    localparam logic [CFG_BITS-1:0] REG_SCALE     = 3'd4;
    localparam logic [CFG_BITS-1:0] REG_REPORT_EN = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_EVENT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

    // Request to the rate divider and its status back.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// File: hdl/dark_pulse_rate_meter.sv
// Channel    | Direction | Contents
// s_axis     | in        | one sample or end-of-event word
// m_axis     | out       | one rate report word per channel
// cfg        | in        | register index and write data
// A sample word does not leave the idle state; the block stays ready for the next word.
// An end-of-event word that reports runs the report sequence for each
// channel and window: the shared divider yields one quotient bit per cycle
// and is run twice per report word, for pulse and single rate.
// Reset (aresetn low, synchronous) clears all counters and loads register defaults.
// A stalled m_tready holds the block in its report sequence.
module dark_pulse_rate_meter #(
    parameter int CHANNELS    = dprm_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS  = dprm_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel, sample_value, baseline (low bit up), zero fill
    input  logic [31:0] s_tdata,
    // operation, first_sample
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // report_channel, pulse_rate, single_rate (low bit up), zero fill
    output logic [71:0] m_tdata,
    // window_kind
    output logic        m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dprm_pkg::CFG_BITS-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import dprm_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW = ((COUNT_BITS > RATE_BITS) ? COUNT_BITS : RATE_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [7:0]  thr_reg;
    logic [15:0] lim_reg;
    logic [31:0] swin_reg, lwin_reg, scale_reg;
    logic        ren_reg;

    logic        pulse_on_reg, pulse_seen_reg;
    logic [15:0] sidx_reg;

    logic [COUNT_BITS-1:0] pul_reg [2][CHANNELS];
    logic [COUNT_BITS-1:0] sgl_reg [2][CHANNELS];
    logic [COUNT_BITS-1:0] smp_reg [2][CHANNELS];

    state_t state_reg, state_next;
    logic   win_reg, win_next;
    logic   both_reg, both_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic   half_reg, half_next;
    logic [RATE_BITS-1:0] prate_reg;

    div_ctl_t div_ctl;
    div_sts_t div_sts;
    logic [RATE_BITS-1:0] quot;
    logic [COUNT_BITS-1:0] div_cnt;

    logic [CH_BITS-1:0]     in_ch;
    logic [SAMPLE_BITS-1:0] in_smp;
    logic [BASE_BITS-1:0]   in_base;
    logic s_acc, is_sample, ch_ok;
    logic [15:0] sidx_eff;
    logic        ip_eff, ps_eff, examine, below, pulse_start;
    logic        short_hit, long_hit, last_ch;

    assign in_ch   = s_tdata[CH_BITS-1:0];
    assign in_smp  = s_tdata[CH_BITS +: SAMPLE_BITS];
    assign in_base = s_tdata[CH_BITS + SAMPLE_BITS +: BASE_BITS];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid & s_tready;
    assign is_sample = (s_tuser[0] == OP_SAMPLE);
    assign ch_ok     = (32'(in_ch) < 32'(CHANNELS));

    assign sidx_eff = s_tuser[1] ? 16'd0 : sidx_reg;
    assign ip_eff   = s_tuser[1] ? 1'b0 : pulse_on_reg;
    assign ps_eff   = s_tuser[1] ? 1'b0 : pulse_seen_reg;
    assign examine  = (sidx_eff < lim_reg);
    assign below    = (17'(in_smp) + 17'(thr_reg)) < 17'(in_base);
    assign pulse_start = examine & below & ~ip_eff;

    assign short_hit = HW'(smp_reg[0][0]) > HW'(swin_reg);
    assign long_hit  = HW'(smp_reg[1][0]) > HW'(lwin_reg);
    assign last_ch   = (32'(ch_reg) == 32'(CHANNELS - 1));

    assign div_cnt = half_reg ? sgl_reg[win_reg][ch_reg] : pul_reg[win_reg][ch_reg];

    dprm_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(div_ctl),
        .count(div_cnt), .scale(scale_reg),
        .divisor(smp_reg[win_reg][ch_reg]),
        .sts(div_sts), .quotient(quot)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        win_next   = win_reg;
        both_next  = both_reg;
        ch_next    = ch_reg;
        half_next  = half_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser[0] == OP_EVENT && ren_reg)
                    state_next = ST_CHECK;
            end
            ST_CHECK: begin
                ch_next   = '0;
                half_next = 1'b0;
                both_next = short_hit & long_hit;
                if (short_hit) begin
                    win_next = 1'b0; state_next = ST_DIV;
                end else if (long_hit) begin
                    win_next = 1'b1; state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    if (!half_reg) half_next = 1'b1;
                    else state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    half_next = 1'b0;
                    if (!last_ch) begin
                        ch_next = ch_reg + CW'(1);
                        state_next = ST_DIV;
                    end else if (both_reg && !win_reg) begin
                        win_next = 1'b1; ch_next = '0; state_next = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        div_ctl.start = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            ST_DIV:  div_ctl.start = ~div_sts.busy & ~div_sts.done;
            ST_OUT:  m_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign m_tdata = {3'b0, quot, prate_reg, CH_BITS'(ch_reg)};
    assign m_tuser = win_reg;
    assign m_tlast = last_ch & ~(both_reg & ~win_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            win_reg <= 1'b0; both_reg <= 1'b0; ch_reg <= '0; half_reg <= 1'b0;
            thr_reg <= 8'd5; lim_reg <= 16'd1000;
            swin_reg <= 32'd50000000; lwin_reg <= 32'd625000000;
            scale_reg <= 32'd125000000; ren_reg <= 1'b1;
            pulse_on_reg <= 1'b0; pulse_seen_reg <= 1'b0; sidx_reg <= '0;
            for (int w = 0; w < 2; w++)
                for (int c = 0; c < CHANNELS; c++) begin
                    pul_reg[w][c] <= '0; sgl_reg[w][c] <= '0; smp_reg[w][c] <= '0;
                end
        end else begin
            state_reg <= state_next;
            win_reg <= win_next; both_reg <= both_next;
            ch_reg <= ch_next; half_reg <= half_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_THRESHOLD: thr_reg   <= cfg_data[7:0];
                    REG_WF_LIMIT:  lim_reg   <= cfg_data[15:0];
                    REG_SHORT_WIN: swin_reg  <= cfg_data;
                    REG_LONG_WIN:  lwin_reg  <= cfg_data;
                    REG_SCALE:     scale_reg <= cfg_data;
                    REG_REPORT_EN: ren_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_acc && is_sample && ch_ok) begin
                for (int w = 0; w < 2; w++) begin
                    if (examine) begin
                        if (smp_reg[w][in_ch[CW-1:0]] != CMAX)
                            smp_reg[w][in_ch[CW-1:0]] <= smp_reg[w][in_ch[CW-1:0]] + 1'b1;
                        if (pulse_start && pul_reg[w][in_ch[CW-1:0]] != CMAX)
                            pul_reg[w][in_ch[CW-1:0]] <= pul_reg[w][in_ch[CW-1:0]] + 1'b1;
                    end
                    if (s_tlast && (ps_eff | pulse_start)
                        && sgl_reg[w][in_ch[CW-1:0]] != CMAX)
                        sgl_reg[w][in_ch[CW-1:0]] <= sgl_reg[w][in_ch[CW-1:0]] + 1'b1;
                end
                if (s_tlast) begin
                    pulse_on_reg <= 1'b0; pulse_seen_reg <= 1'b0; sidx_reg <= '0;
                end else begin
                    pulse_on_reg   <= examine ? below : ip_eff;
                    pulse_seen_reg <= ps_eff | pulse_start;
                    sidx_reg <= (sidx_eff == 16'hFFFF) ? sidx_eff : sidx_eff + 16'd1;
                end
            end
            // Clear each channel of the window once its word is taken.
            if (state_reg == ST_OUT && m_tready) begin
                pul_reg[win_reg][ch_reg] <= '0;
                sgl_reg[win_reg][ch_reg] <= '0;
                smp_reg[win_reg][ch_reg] <= '0;
            end
        end
        if (state_reg == ST_DIV && div_sts.done && !half_reg)
            prate_reg <= quot;
    end

    a_out_only_in_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("output while accepting input");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.start |-> !div_sts.busy) else $error("divider restarted while busy");
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("report word changed under stall");

endmodule

// File: hdl/dprm_divider.sv
module dprm_divider #(
    parameter int COUNT_BITS = dprm_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dprm_pkg::div_ctl_t            ctl,
    input  logic [COUNT_BITS-1:0]         count,
    input  logic [dprm_pkg::RATE_BITS-1:0] scale,
    input  logic [COUNT_BITS-1:0]         divisor,
    output dprm_pkg::div_sts_t            sts,
    output logic [dprm_pkg::RATE_BITS-1:0] quotient
);
    import dprm_pkg::*;

    // Restoring division of count*scale by divisor, one quotient bit per cycle.
    // Quotient is kept COUNT_BITS bits wider than the output so saturation can be detected.
    localparam int PW = COUNT_BITS + RATE_BITS;
    localparam int SW = $clog2(PW + 1);

    logic [PW-1:0]          num_reg, num_next;
    logic [COUNT_BITS:0]    rem_reg, rem_next;
    logic [PW-1:0]          q_reg, q_next;
    logic [SW-1:0]          step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   mul_reg, mul_next;
    logic [COUNT_BITS:0]    trial;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        mul_next  = 1'b0;
        done_next = 1'b0;
        trial     = '0;
        if (ctl.start) begin
            busy_next = 1'b1;
            mul_next  = 1'b1;
            rem_next  = '0;
            q_next    = '0;
            step_next = SW'(PW);
        end else if (mul_reg) begin
            num_next = PW'(count) * PW'(scale);
        end else if (busy_reg) begin
            trial    = {rem_reg[COUNT_BITS-1:0], num_reg[PW-1]};
            num_next = {num_reg[PW-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
                q_next   = {q_reg[PW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[PW-2:0], 1'b0};
            end
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mul_reg  <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mul_reg  <= mul_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign sts.busy = busy_reg | mul_reg;
    assign sts.done = done_reg;
    assign quotient = (divisor == '0) ? '0 :
                      (|q_reg[PW-1:RATE_BITS]) ? '1 : q_reg[RATE_BITS-1:0];

endmodule

// File: verif/dprm_checker.sv
module dprm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          reports_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dprm_pkg::*;

    localparam int NCH = 20;

    typedef struct packed {
        logic        kind;
        logic [4:0]  chan;
        logic [31:0] pulse_rate;
        logic [31:0] single_rate;
        logic        last;
    } rate_word_t;

    rate_word_t report_queue[$];

    logic [7:0]  thr_offset;
    logic [15:0] wf_limit;
    logic [31:0] short_win, long_win, scale;
    logic        report_en;

    logic        pulse_on, pulse_seen;
    logic [15:0] wf_index;
    logic [31:0] pulses[2][NCH];
    logic [31:0] singles[2][NCH];
    logic [31:0] samples[2][NCH];

    assign reports_pending = report_queue.size();

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] hz_rate(logic [31:0] count, logic [31:0] samp);
        logic [95:0] q;
        if (samp == 0) return 32'd0;
        q = ({64'd0, count} * {64'd0, scale}) / {64'd0, samp};
        return (q > 96'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic close_window(int w);
        rate_word_t r;
        for (int c = 0; c < NCH; c++) begin
            r.kind = w[0];
            r.chan = c[4:0];
            r.pulse_rate = hz_rate(pulses[w][c], samples[w][c]);
            r.single_rate = hz_rate(singles[w][c], samples[w][c]);
            r.last = 1'b0;
            report_queue.insert(report_queue.size(), r);
            pulses[w][c] = 0;
            singles[w][c] = 0;
            samples[w][c] = 0;
        end
    endtask

    task automatic take_word(logic [31:0] d, logic [1:0] u, logic lst);
        logic [4:0]  ch;
        logic [12:0] lvl;
        logic        below;
        int          n0;
        rate_word_t  r;
        ch = d[4:0];
        if (u[0] == OP_EVENT) begin
            if (!report_en) return;
            n0 = report_queue.size();
            if (samples[0][0] > short_win) close_window(0);
            if (samples[1][0] > long_win) close_window(1);
            if (report_queue.size() > n0) begin
                r = report_queue.pop_back();
                r.last = 1'b1;
                report_queue.insert(report_queue.size(), r);
            end
            return;
        end
        if (ch >= NCH) return;
        if (u[1]) begin
            pulse_on = 0;
            pulse_seen = 0;
            wf_index = 0;
        end
        if (wf_index < wf_limit) begin
            lvl = {1'b0, d[16:5]} + {5'd0, thr_offset};
            below = lvl < {1'b0, d[28:17]};
            if (below && !pulse_on) begin
                pulse_on = 1;
                pulse_seen = 1;
                for (int w = 0; w < 2; w++) pulses[w][ch] = bump(pulses[w][ch]);
            end else if (!below && pulse_on) begin
                pulse_on = 0;
            end
            for (int w = 0; w < 2; w++) samples[w][ch] = bump(samples[w][ch]);
        end
        if (wf_index != 16'hFFFF) wf_index++;
        if (lst) begin
            if (pulse_seen)
                for (int w = 0; w < 2; w++) singles[w][ch] = bump(singles[w][ch]);
            pulse_on = 0;
            pulse_seen = 0;
            wf_index = 0;
        end
    endtask

    always @(posedge aclk) begin
        rate_word_t got, want;
        if (!aresetn) begin
            thr_offset <= 8'd5;
            wf_limit <= 16'd1000;
            short_win <= 32'd50000000;
            long_win <= 32'd625000000;
            scale <= 32'd125000000;
            report_en <= 1'b1;
            pulse_on = 0;
            pulse_seen = 0;
            wf_index = 0;
            for (int w = 0; w < 2; w++)
                for (int c = 0; c < NCH; c++) begin
                    pulses[w][c] = 0;
                    singles[w][c] = 0;
                    samples[w][c] = 0;
                end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: thr_offset <= cfg_data[7:0];
                    REG_WF_LIMIT:  wf_limit <= cfg_data[15:0];
                    REG_SHORT_WIN: short_win <= cfg_data;
                    REG_LONG_WIN:  long_win <= cfg_data;
                    REG_SCALE:     scale <= cfg_data;
                    REG_REPORT_EN: report_en <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_word(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[4:0], m_tdata[36:5], m_tdata[68:37], m_tlast};
                if (report_queue.size() == 0) begin
                    report("rate word with none expected");
                end else begin
                    want = report_queue.pop_front();
                    if (got.kind !== want.kind) report("window_kind");
                    if (got.chan !== want.chan) report("report_channel");
                    if (got.pulse_rate !== want.pulse_rate) report("pulse_rate");
                    if (got.single_rate !== want.single_rate) report("single_rate");
                    if (got.last !== want.last) report("last_report");
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dprm_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;
    int          fail_count;
    int          reports_pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    always #4 aclk = ~aclk;

    dark_pulse_rate_meter i_dut (.*);

    dprm_checker i_checker (.*);

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on accepted words of any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic send_word(logic op, logic [4:0] ch, logic [11:0] smp, logic [11:0] base,
                             logic first, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tdata <= {3'd0, base, smp, ch};
        s_tuser <= {first, op};
        s_tlast <= lst;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_reports();
        s_tvalid <= 0;
        do @(posedge aclk); while (reports_pending != 0);
        repeat (6000) @(posedge aclk);
    endtask

    task automatic end_event();
        send_word(OP_EVENT, 5'($urandom), 12'($urandom), 12'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    // One waveform of random length on one channel; mostly well formed.
    task automatic send_waveform();
        int len, ch;
        logic [11:0] base;
        len = $urandom_range(1, 8);
        ch = ($urandom_range(9) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19);
        base = 12'($urandom);
        for (int i = 0; i < len; i++)
            send_word(OP_SAMPLE, 5'(ch), ($urandom_range(1) ? 12'($urandom) : base),
                      base, (i == 0) || ($urandom_range(15) == 0),
                      (i == len - 1) && ($urandom_range(7) != 0));
    endtask

    initial begin
        int idle_sets[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{29, 29}};
        int sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: small windows so that reports come often.
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_WF_LIMIT, 3);
        write_reg(REG_SHORT_WIN, 2);
        write_reg(REG_LONG_WIN, 5);
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_REPORT_EN, 1);
        send_word(OP_SAMPLE, 0, 0, 12'hFFF, 1, 0);
        send_word(OP_SAMPLE, 0, 12'hFFF, 12'hFFF, 0, 0);
        send_word(OP_SAMPLE, 0, 0, 12'hFFF, 0, 0);
        send_word(OP_SAMPLE, 0, 0, 12'hFFF, 0, 1);
        send_word(OP_SAMPLE, 19, 12'hFFF, 0, 1, 1);
        send_word(OP_SAMPLE, 31, 0, 12'hFFF, 1, 1);
        send_word(OP_SAMPLE, 5, 10, 12, 1, 1);
        send_word(OP_EVENT, 0, 0, 0, 0, 0);
        send_word(OP_EVENT, 31, 12'hFFF, 12'hFFF, 1, 1);
        drain_reports();
        write_reg(REG_THRESHOLD, 255);
        write_reg(REG_WF_LIMIT, 0);
        write_reg(REG_SCALE, 1);
        send_word(OP_SAMPLE, 1, 0, 200, 1, 1);
        send_word(OP_SAMPLE, 0, 0, 12'hFFF, 1, 1);
        send_word(OP_EVENT, 0, 0, 0, 0, 0);
        drain_reports();
        write_reg(REG_REPORT_EN, 0);
        write_reg(REG_WF_LIMIT, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_word(OP_SAMPLE, 0, 0, 12'hFFF, i == 0, i == 3);
        send_word(OP_EVENT, 0, 0, 0, 0, 0);
        drain_reports();

        // Random phases with varied settings.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_THRESHOLD,
                      32'($urandom_range(0, 1) ? $urandom_range(255) : $urandom_range(8)));
            write_reg(REG_WF_LIMIT, (p == 3) ? 32'hFFFF : 32'($urandom_range(1, 6)));
            write_reg(REG_SHORT_WIN, (p == 2) ? 32'hFFFF_FFFF : $urandom_range(1, 12));
            write_reg(REG_LONG_WIN, $urandom_range(1, 30));
            write_reg(REG_SCALE, (p == 0) ? 32'd125000000 : $urandom);
            write_reg(REG_REPORT_EN, p != 1 || $urandom_range(1));
            send_idle_pct = idle_sets[p][0];
            recv_stall_pct = idle_sets[p][1];
            sent = 0;
            while (sent < 75) begin
                if ($urandom_range(4) == 0) begin
                    end_event();
                    sent++;
                end else begin
                    send_waveform();
                    sent += 4;
                end
            end
            end_event();
            drain_reports();
        end

        recv_stall_pct = 0;
        drain_reports();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: dark_pulse_rate_meter.f
hdl/dprm_pkg.sv
hdl/dprm_divider.sv
hdl/dark_pulse_rate_meter.sv
verif/dprm_checker.sv
verif/tb_top.sv
